FILE: rtl/iri_pkg.sv
// Package for the image resize interpolator: widths, codes, FSM states and
// the divider request/response structs. Depends on nothing.
package iri_pkg;

    localparam int PIXEL_BITS = 16;
    localparam int FRAC       = 16;
    localparam int ONE_Q      = 1 << FRAC;
    localparam int IN_DIM_W   = 9;
    localparam int OUT_DIM_W  = 13;
    localparam int POS_W      = 12;
    localparam int NUM_W      = 38;
    localparam int DEN_W      = 14;
    localparam int WGT_W      = 19;
    localparam int T_W        = 18;
    localparam int SQ_W       = 2 * T_W;
    localparam int CUBE_W     = SQ_W + T_W;
    localparam int POLY_W     = 56;
    localparam int COORD_W    = IN_DIM_W + FRAC;
    localparam int WPROD_W    = 2 * WGT_W;
    localparam int TPROD_W    = WPROD_W + PIXEL_BITS;
    localparam int ACC_W      = 56;
    localparam int APB_ADDR_W = 5;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef logic [1:0] mode_t;
    localparam mode_t MODE_NEAREST  = 2'd0;
    localparam mode_t MODE_BILINEAR = 2'd1;
    localparam mode_t MODE_BICUBIC  = 2'd2;

    typedef logic [2:0] reg_idx_t;
    localparam reg_idx_t REG_IN_HEIGHT  = 3'd0;
    localparam reg_idx_t REG_IN_WIDTH   = 3'd1;
    localparam reg_idx_t REG_OUT_HEIGHT = 3'd2;
    localparam reg_idx_t REG_OUT_WIDTH  = 3'd3;
    localparam reg_idx_t REG_MODE       = 3'd4;
    localparam reg_idx_t REG_ALIGN      = 3'd5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_COORD,
        S_WGT,
        S_TAPS,
        S_DRAIN,
        S_FIN
    } state_t;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quot;
    } div_rsp_t;

endpackage

FILE: rtl/iri_if.sv
// Request and result channel interfaces of the image resize interpolator.
// Depends on iri_pkg.
interface iri_req_if import iri_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic                         req_type;
    logic [POS_W-1:0]             row;
    logic [POS_W-1:0]             col;
    logic signed [PIXEL_BITS-1:0] pixel_in;

    modport source (output valid, req_type, row, col, pixel_in, input ready);
    modport sink   (input valid, req_type, row, col, pixel_in, output ready);
endinterface

interface iri_res_if import iri_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic signed [PIXEL_BITS-1:0] pixel_out;
    logic                         saturated;
    logic                         bad_coordinate;

    modport source (output valid, pixel_out, saturated, bad_coordinate, input ready);
    modport sink   (input valid, pixel_out, saturated, bad_coordinate, output ready);
endinterface

FILE: rtl/iri_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// Depends on nothing.
module iri_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: rtl/iri_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on iri_pkg.
module iri_div import iri_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] rem_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   trial;
    logic             fits;
    logic [DEN_W:0]   diff;

    always_comb
    begin
        trial = {rem_reg, quo_reg[NUM_W-1]};
        fits  = trial >= {1'b0, den_reg};
        diff  = trial - {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.num;
            den_reg <= req.den;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;
endmodule

FILE: rtl/image_resize_interpolator_top.sv
// Top level of the image resize interpolator: APB registers, frame store,
// coordinate dividers, kernel weight unit and tap accumulator.
// Depends on iri_pkg, iri_if, iri_ram and iri_div.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------
//  req     | in  | valid/ready        | req_type, row, col, pixel_in
//  res     | out | valid/ready        | pixel_out, saturated, bad_coordinate
//  apb     | in  | psel/penable/pready| paddr, pwrite, pwdata, prdata
//
// Steps: a load in the plane writes the frame store. A query runs the
// coordinate dividers, then, in bicubic mode only, the shared 18x18
// multiplier for the eight cubic weights, then one frame store read per
// tap and a drain of the tap pipeline.
// Reset sets APB register defaults and clears control; datapath and frame store are not cleared.
// One item is in flight at a time; the result register frees the engine,
// so the next item is taken while a result waits on a stalled sink.
module image_resize_interpolator_top import iri_pkg::*; #(
    parameter int MAX_IN_HEIGHT = 256,
    parameter int MAX_IN_WIDTH  = 256,
    parameter int MAX_OUT_DIM   = 4096
) (
    input  logic                  clk,
    input  logic                  rst_n,
    iri_req_if.sink               req,
    iri_res_if.source             res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    localparam int STORE_DEPTH = MAX_IN_HEIGHT * MAX_IN_WIDTH;
    localparam int ADDR_W      = STORE_DEPTH > 1 ? $clog2(STORE_DEPTH) : 1;

    // ---------------------------------------------------------------- registers
    logic [IN_DIM_W-1:0]  in_height_reg;
    logic [IN_DIM_W-1:0]  in_width_reg;
    logic [OUT_DIM_W-1:0] out_height_reg;
    logic [OUT_DIM_W-1:0] out_width_reg;
    mode_t                interp_mode_reg;
    logic                 align_corners_reg;
    reg_idx_t             apb_idx;

    assign apb_idx = paddr[APB_ADDR_W-1:2];
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_height_reg     <= IN_DIM_W'(1);
            in_width_reg      <= IN_DIM_W'(1);
            out_height_reg    <= OUT_DIM_W'(1);
            out_width_reg     <= OUT_DIM_W'(1);
            interp_mode_reg   <= MODE_NEAREST;
            align_corners_reg <= 1'b0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (apb_idx)
                REG_IN_HEIGHT:  in_height_reg     <= pwdata[IN_DIM_W-1:0];
                REG_IN_WIDTH:   in_width_reg      <= pwdata[IN_DIM_W-1:0];
                REG_OUT_HEIGHT: out_height_reg    <= pwdata[OUT_DIM_W-1:0];
                REG_OUT_WIDTH:  out_width_reg     <= pwdata[OUT_DIM_W-1:0];
                REG_MODE:       interp_mode_reg   <= pwdata[1:0];
                REG_ALIGN:      align_corners_reg <= pwdata[0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (apb_idx)
            REG_IN_HEIGHT:  prdata = 32'(in_height_reg);
            REG_IN_WIDTH:   prdata = 32'(in_width_reg);
            REG_OUT_HEIGHT: prdata = 32'(out_height_reg);
            REG_OUT_WIDTH:  prdata = 32'(out_width_reg);
            REG_MODE:       prdata = 32'(interp_mode_reg);
            REG_ALIGN:      prdata = 32'(align_corners_reg);
            default:        prdata = '0;
        endcase
    end

    // Effective sizes: zero counts as one, too large clamps to the maximum.
    logic [IN_DIM_W-1:0]  ih, iw;
    logic [OUT_DIM_W-1:0] oh, ow;
    logic                 interp, bicubic;

    always_comb
    begin
        ih = (in_height_reg == '0) ? IN_DIM_W'(1) :
             (32'(in_height_reg) > MAX_IN_HEIGHT) ? IN_DIM_W'(MAX_IN_HEIGHT) : in_height_reg;
        iw = (in_width_reg == '0) ? IN_DIM_W'(1) :
             (32'(in_width_reg) > MAX_IN_WIDTH) ? IN_DIM_W'(MAX_IN_WIDTH) : in_width_reg;
        oh = (out_height_reg == '0) ? OUT_DIM_W'(1) :
             (32'(out_height_reg) > MAX_OUT_DIM) ? OUT_DIM_W'(MAX_OUT_DIM) : out_height_reg;
        ow = (out_width_reg == '0) ? OUT_DIM_W'(1) :
             (32'(out_width_reg) > MAX_OUT_DIM) ? OUT_DIM_W'(MAX_OUT_DIM) : out_width_reg;
        bicubic = interp_mode_reg == MODE_BICUBIC;
        interp  = (interp_mode_reg == MODE_BILINEAR) || bicubic;
    end

    // Divider operands for one axis. Nearest divides o*in by out; the
    // interpolating modes divide the Q16 source coordinate numerator.
    function automatic div_req_t axis_div(
        logic [POS_W-1:0]     o,
        logic [IN_DIM_W-1:0]  n_in,
        logic [OUT_DIM_W-1:0] n_out,
        logic                 use_interp,
        logic                 ac
    );
        logic signed [NUM_W:0] half_num;
        div_req_t              r;
        r.start  = 1'b1;
        half_num = $signed((NUM_W+1)'({o, 1'b1}) * (NUM_W+1)'(n_in))
                 - $signed((NUM_W+1)'(n_out));
        if (!use_interp)
        begin
            r.num = NUM_W'(o) * NUM_W'(n_in);
            r.den = DEN_W'(n_out);
        end
        else if (ac)
        begin
            if (n_out == OUT_DIM_W'(1))
            begin
                r.num = '0;
                r.den = DEN_W'(1);
            end
            else
            begin
                r.num = (NUM_W'(o) * NUM_W'(n_in - 1'b1)) << FRAC;
                r.den = DEN_W'(n_out - 1'b1);
            end
        end
        else if (half_num <= 0)
        begin
            r.num = '0;
            r.den = DEN_W'(1);
        end
        else
        begin
            r.num = NUM_W'(half_num) << FRAC;
            r.den = {n_out, 1'b0};
        end
        return r;
    endfunction

    // Tap index base+step(-1), clamped to [0, n-1].
    function automatic logic [IN_DIM_W-1:0] clamp_tap(
        logic [IN_DIM_W-1:0] base,
        logic [1:0]          step,
        logic                back,
        logic [IN_DIM_W-1:0] n
    );
        logic signed [IN_DIM_W+1:0] v;
        logic signed [IN_DIM_W+1:0] top;
        v   = $signed({2'b0, base}) + $signed({{IN_DIM_W{1'b0}}, step})
            - $signed({{(IN_DIM_W+1){1'b0}}, back});
        top = $signed({2'b0, n}) - $signed((IN_DIM_W+2)'(1));
        if (v < 0)
        begin
            return '0;
        end
        else if (v > top)
        begin
            return n - 1'b1;
        end
        return v[IN_DIM_W-1:0];
    endfunction

    // ---------------------------------------------------------------- control
    state_t state_reg, state_next;
    logic   load_out;
    logic   req_accept;
    logic   is_query;
    logic   bad_load, bad_query;
    logic   good_query;
    logic   zero_res_reg;
    logic   bad_reg;

    logic [1:0]      ta_reg, tb_reg, tap_last;
    logic [2:0]      wk_reg;
    logic [1:0]      wstep_reg;
    logic            p1_valid_reg, p2_valid_reg;
    logic            out_valid_reg;
    div_req_t        div_y_req, div_x_req;
    div_rsp_t        div_y_rsp, div_x_rsp;

    assign is_query   = req.req_type == REQ_QUERY;
    assign bad_load   = (32'(req.row) >= 32'(ih)) || (32'(req.col) >= 32'(iw));
    assign bad_query  = (32'(req.row) >= 32'(oh)) || (32'(req.col) >= 32'(ow));
    assign req_accept = req.valid && req.ready;
    assign good_query = req_accept && is_query && !bad_query;
    assign tap_last   = bicubic ? 2'd3 : (interp ? 2'd1 : 2'd0);

    always_comb
    begin
        state_next = state_reg;
        req.ready  = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    state_next = (is_query && !bad_query) ? S_DIV : S_FIN;
                end
            end
            S_DIV:
            begin
                if (div_y_rsp.done)
                begin
                    state_next = S_COORD;
                end
            end
            S_COORD:
            begin
                state_next = bicubic ? S_WGT : S_TAPS;
            end
            S_WGT:
            begin
                if (wstep_reg == 2'd3 && wk_reg == 3'd7)
                begin
                    state_next = S_TAPS;
                end
            end
            S_TAPS:
            begin
                if (ta_reg == tap_last && tb_reg == tap_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!p1_valid_reg && !p2_valid_reg)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ta_reg        <= '0;
            tb_reg        <= '0;
            wk_reg        <= '0;
            wstep_reg     <= '0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            zero_res_reg  <= 1'b0;
            bad_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            p1_valid_reg <= state_reg == S_TAPS;
            p2_valid_reg <= p1_valid_reg;
            if (req_accept)
            begin
                zero_res_reg <= !is_query || bad_query;
                bad_reg      <= is_query ? bad_query : bad_load;
            end
            if (state_reg == S_COORD)
            begin
                ta_reg    <= '0;
                tb_reg    <= '0;
                wk_reg    <= '0;
                wstep_reg <= '0;
            end
            if (state_reg == S_WGT)
            begin
                wstep_reg <= wstep_reg + 1'b1;
                if (wstep_reg == 2'd3)
                begin
                    wk_reg <= wk_reg + 1'b1;
                end
            end
            // Walk taps column first, then advance the row.
            if (state_reg == S_TAPS)
            begin
                if (tb_reg == tap_last)
                begin
                    tb_reg <= '0;
                    ta_reg <= ta_reg + 1'b1;
                end
                else
                begin
                    tb_reg <= tb_reg + 1'b1;
                end
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- dividers
    always_comb
    begin
        div_y_req       = axis_div(req.row, ih, oh, interp, align_corners_reg);
        div_x_req       = axis_div(req.col, iw, ow, interp, align_corners_reg);
        div_y_req.start = good_query;
        div_x_req.start = good_query;
    end

    iri_div u_div_y (.clk(clk), .rst_n(rst_n), .req(div_y_req), .rsp(div_y_rsp));
    iri_div u_div_x (.clk(clk), .rst_n(rst_n), .req(div_x_req), .rsp(div_x_rsp));

    // Source coordinates in Q16, clamped to (in-1)*2^16. Nearest yields a
    // whole index, so lift it to Q16 to share the tap path.
    logic [COORD_W-1:0] yc_reg, xc_reg;
    logic [COORD_W-1:0] y_hi, x_hi;
    logic [NUM_W-1:0]   yq, xq;

    always_comb
    begin
        y_hi = {ih - 1'b1, {FRAC{1'b0}}};
        x_hi = {iw - 1'b1, {FRAC{1'b0}}};
        yq   = interp ? div_y_rsp.quot : (div_y_rsp.quot << FRAC);
        xq   = interp ? div_x_rsp.quot : (div_x_rsp.quot << FRAC);
    end

    logic [IN_DIM_W-1:0] yi, xi;
    logic [FRAC-1:0]     fy, fx;
    assign yi = yc_reg[COORD_W-1:FRAC];
    assign xi = xc_reg[COORD_W-1:FRAC];
    assign fy = yc_reg[FRAC-1:0];
    assign fx = xc_reg[FRAC-1:0];

    // ---------------------------------------------------------------- weights
    // Catmull-Rom weight per tap distance t: square, then cube in two halves
    // through one 18x18 multiplier, then the polynomial rounded to Q16.
    logic signed [WGT_W-1:0] wy_reg [4];
    logic signed [WGT_W-1:0] wx_reg [4];
    logic [SQ_W-1:0]         t2_reg;
    logic [SQ_W-1:0]         lo_reg;
    logic [CUBE_W-1:0]       t3_reg;
    logic [FRAC-1:0]         wf;
    logic [T_W-1:0]          t;
    logic [T_W-1:0]          mul_a;
    logic [SQ_W-1:0]         mul_p;
    logic signed [POLY_W-1:0] t3s, t2s, t1s, poly;
    logic signed [WGT_W-1:0] wgt;

    always_comb
    begin
        wf = wk_reg[2] ? fx : fy;
        unique case (wk_reg[1:0])
            2'd0:    t = T_W'(ONE_Q) + T_W'(wf);
            2'd1:    t = T_W'(wf);
            2'd2:    t = T_W'(ONE_Q) - T_W'(wf);
            default: t = T_W'(2 * ONE_Q) - T_W'(wf);
        endcase
        unique case (wstep_reg)
            2'd0:    mul_a = t;
            2'd1:    mul_a = t2_reg[T_W-1:0];
            default: mul_a = t2_reg[SQ_W-1:T_W];
        endcase
        mul_p = SQ_W'(mul_a) * SQ_W'(t);

        t3s = $signed(POLY_W'(t3_reg));
        t2s = $signed(POLY_W'(t2_reg) << FRAC);
        t1s = $signed(POLY_W'(t) << 32);
        if (32'(t) <= ONE_Q)
        begin
            poly = 3 * t3s - 5 * t2s + ($signed(POLY_W'(2)) <<< 48);
        end
        else if (32'(t) < 2 * ONE_Q)
        begin
            poly = -t3s + 5 * t2s - 8 * t1s + ($signed(POLY_W'(4)) <<< 48);
        end
        else
        begin
            poly = '0;
        end
        // Round to nearest, half upward, on the way to Q16.
        wgt = WGT_W'((poly + ($signed(POLY_W'(1)) <<< 32)) >>> 33);
    end

    // ---------------------------------------------------------------- taps
    logic [IN_DIM_W-1:0]           tr, tc;
    logic [ADDR_W-1:0]             raddr, waddr;
    logic [PIXEL_BITS-1:0]         rdata;
    logic                          ram_we;
    logic signed [WPROD_W-1:0]     wprod_reg;
    logic signed [TPROD_W-1:0]     tprod_reg;
    logic signed [ACC_W-1:0]       acc_reg;

    always_comb
    begin
        tr     = clamp_tap(yi, ta_reg, bicubic, ih);
        tc     = clamp_tap(xi, tb_reg, bicubic, iw);
        raddr  = ADDR_W'(32'(tr) * MAX_IN_WIDTH + 32'(tc));
        waddr  = ADDR_W'(32'(req.row) * MAX_IN_WIDTH + 32'(req.col));
        ram_we = req_accept && !is_query && !bad_load;
    end

    iri_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (req.pixel_in),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk)
    begin
        if (state_reg == S_DIV && div_y_rsp.done)
        begin
            yc_reg <= (yq > NUM_W'(y_hi)) ? y_hi : COORD_W'(yq);
            xc_reg <= (xq > NUM_W'(x_hi)) ? x_hi : COORD_W'(xq);
        end
        if (state_reg == S_COORD)
        begin
            acc_reg <= '0;
            if (interp)
            begin
                wy_reg[0] <= $signed(WGT_W'(T_W'(ONE_Q) - T_W'(fy)));
                wy_reg[1] <= $signed(WGT_W'(fy));
                wx_reg[0] <= $signed(WGT_W'(T_W'(ONE_Q) - T_W'(fx)));
                wx_reg[1] <= $signed(WGT_W'(fx));
            end
            else
            begin
                wy_reg[0] <= $signed(WGT_W'(ONE_Q));
                wx_reg[0] <= $signed(WGT_W'(ONE_Q));
            end
        end
        if (state_reg == S_WGT)
        begin
            unique case (wstep_reg)
                2'd0:    t2_reg <= mul_p;
                2'd1:    lo_reg <= mul_p;
                2'd2:    t3_reg <= {mul_p, {T_W{1'b0}}} + CUBE_W'(lo_reg);
                default:
                begin
                    if (wk_reg[2])
                    begin
                        wx_reg[wk_reg[1:0]] <= wgt;
                    end
                    else
                    begin
                        wy_reg[wk_reg[1:0]] <= wgt;
                    end
                end
            endcase
        end
        // Three stages: weight product with the read, pixel product, add.
        if (state_reg == S_TAPS)
        begin
            wprod_reg <= WPROD_W'(wy_reg[ta_reg]) * WPROD_W'(wx_reg[tb_reg]);
        end
        if (p1_valid_reg)
        begin
            tprod_reg <= TPROD_W'(wprod_reg) * TPROD_W'($signed(rdata));
        end
        if (p2_valid_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(tprod_reg);
        end
    end

    // ---------------------------------------------------------------- result
    localparam int RND_W = ACC_W - 32;
    logic signed [ACC_W-1:0]      rnd_full;
    logic signed [RND_W-1:0]      rnd;
    logic signed [PIXEL_BITS-1:0] pix_next;
    logic                         sat_next;
    logic signed [PIXEL_BITS-1:0] pix_reg;
    logic                         sat_reg;
    logic                         bad_out_reg;

    always_comb
    begin
        rnd_full = (acc_reg + ($signed(ACC_W'(1)) <<< 31)) >>> 32;
        rnd      = RND_W'(rnd_full);
        sat_next = 1'b0;
        if (rnd > $signed(RND_W'((1 << (PIXEL_BITS - 1)) - 1)))
        begin
            pix_next = {1'b0, {(PIXEL_BITS-1){1'b1}}};
            sat_next = 1'b1;
        end
        else if (rnd < -$signed(RND_W'(1 << (PIXEL_BITS - 1))))
        begin
            pix_next = {1'b1, {(PIXEL_BITS-1){1'b0}}};
            sat_next = 1'b1;
        end
        else
        begin
            pix_next = PIXEL_BITS'(rnd);
        end
        if (zero_res_reg)
        begin
            pix_next = '0;
            sat_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            pix_reg     <= pix_next;
            sat_reg     <= sat_next;
            bad_out_reg <= bad_reg;
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.pixel_out      = pix_reg;
    assign res.saturated      = sat_reg;
    assign res.bad_coordinate = bad_out_reg;

    // ---------------------------------------------------------------- checks
    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        div_y_rsp.done == div_x_rsp.done)
        else $error("coordinate dividers out of step");

    a_pipe_in_taps: assert property (@(posedge clk) disable iff (!rst_n)
        p2_valid_reg |-> (state_reg == S_TAPS || state_reg == S_DRAIN))
        else $error("tap pipeline active outside tap walk");

    a_bad_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.bad_coordinate) |-> (res.pixel_out == '0 && !res.saturated))
        else $error("bad coordinate transfer carries a pixel");
endmodule

FILE: test/tb_image_resize_interpolator_top.sv
// Self-checking testbench of image_resize_interpolator_top: loads and queries
// in nearest, bilinear and bicubic modes, checked against a local predictor.
// Depends on iri_pkg, iri_if and the RTL of the block.
`timescale 1ns / 1ps

module tb_image_resize_interpolator_top;
    import iri_pkg::*;

    localparam mode_t MODE_UNUSED = 2'd3;
    localparam int    STORE_W     = 256;
    localparam int    WATCH_LIMIT = 50000;

    typedef struct {
        logic signed [PIXEL_BITS-1:0] pixel;
        logic                         sat;
        logic                         bad;
    } pix_result_t;

    // Pixel predictor and the queue of results still owed by the block.
    class resize_scoreboard;
        logic [PIXEL_BITS-1:0] store [STORE_W*STORE_W];
        logic [12:0]           dims [4];
        mode_t                 mode;
        logic                  align;
        pix_result_t           owed [$];
        int                    mismatches;

        function new();
            foreach (dims[i]) dims[i] = 13'd1;
            mode  = MODE_NEAREST;
            align = 1'b0;
            mismatches = 0;
            foreach (store[i]) store[i] = '0;
        endfunction

        function void set_reg(reg_idx_t idx, logic [31:0] v);
            case (idx)
                REG_IN_HEIGHT:  dims[0] = 13'(v[8:0]);
                REG_IN_WIDTH:   dims[1] = 13'(v[8:0]);
                REG_OUT_HEIGHT: dims[2] = v[12:0];
                REG_OUT_WIDTH:  dims[3] = v[12:0];
                REG_MODE:       mode = v[1:0];
                REG_ALIGN:      align = v[0];
                default: ;
            endcase
        endfunction

        function int eff(int i);
            int hi;
            hi = (i < 2) ? STORE_W : 4096;
            if (dims[i] < 1) return 1;
            if (dims[i] > hi) return hi;
            return int'(dims[i]);
        endfunction

        function longint rnd_shift(longint v, int s);
            return (v + (64'sd1 << (s - 1))) >>> s;
        endfunction

        function longint src_pos(int o, int n_in, int n_out);
            longint y, hi, num;
            hi = longint'(n_in - 1) << FRAC;
            if (align)
                y = (n_out > 1) ? ((longint'(o) * (n_in - 1)) << FRAC) / (n_out - 1) : 0;
            else begin
                num = longint'(2 * o + 1) * n_in - n_out;
                y = (num > 0) ? (num << FRAC) / (2 * longint'(n_out)) : 0;
            end
            return (y > hi) ? hi : y;
        endfunction

        function longint cubic_wgt(longint d);
            longint t, t2, t3;
            t  = (d < 0) ? -d : d;
            t2 = t * t;
            t3 = t2 * t;
            if (t <= ONE_Q)
                return rnd_shift(3 * t3 - 5 * (t2 << 16) + (64'sd2 << 48), 33);
            if (t < 2 * ONE_Q)
                return rnd_shift(-t3 + 5 * (t2 << 16) - 8 * (t << 32) + (64'sd4 << 48), 33);
            return 0;
        endfunction

        function int clip_idx(longint v, int n);
            if (v < 0) return 0;
            if (v > n - 1) return n - 1;
            return int'(v);
        endfunction

        function longint pix(int r, int c);
            return longint'($signed(store[r * STORE_W + c]));
        endfunction

        // note an accepted request and queue the result it will produce
        function void note_request(logic kind, int r, int c, logic [PIXEL_BITS-1:0] p);
            pix_result_t e;
            int ih, iw, oh, ow, y0, x0, y1, x1, rr, cc;
            longint y, x, fy, fx, acc, v;
            longint wy [4];
            longint wx [4];
            ih = eff(0); iw = eff(1); oh = eff(2); ow = eff(3);
            e = '{pixel: '0, sat: 1'b0, bad: 1'b0};
            if (kind == REQ_LOAD) begin
                if (r >= ih || c >= iw) e.bad = 1'b1;
                else store[r * STORE_W + c] = p;
            end else if (r >= oh || c >= ow) begin
                e.bad = 1'b1;
            end else begin
                if (mode == MODE_BILINEAR || mode == MODE_BICUBIC) begin
                    y = src_pos(r, ih, oh);
                    x = src_pos(c, iw, ow);
                    y0 = int'(y >>> FRAC);
                    x0 = int'(x >>> FRAC);
                    fy = y & (ONE_Q - 1);
                    fx = x & (ONE_Q - 1);
                end
                if (mode == MODE_BILINEAR) begin
                    y1 = clip_idx(y0 + 1, ih);
                    x1 = clip_idx(x0 + 1, iw);
                    acc = (ONE_Q - fy) * (ONE_Q - fx) * pix(y0, x0)
                        + (ONE_Q - fy) * fx * pix(y0, x1)
                        + fy * (ONE_Q - fx) * pix(y1, x0)
                        + fy * fx * pix(y1, x1);
                    v = rnd_shift(acc, 32);
                end else if (mode == MODE_BICUBIC) begin
                    acc = 0;
                    for (int a = 0; a < 4; a++) begin
                        wy[a] = cubic_wgt(fy - longint'(a - 1) * ONE_Q);
                        wx[a] = cubic_wgt(fx - longint'(a - 1) * ONE_Q);
                    end
                    for (int a = 0; a < 4; a++) begin
                        rr = clip_idx(y0 + a - 1, ih);
                        for (int b = 0; b < 4; b++) begin
                            cc = clip_idx(x0 + b - 1, iw);
                            acc += wy[a] * wx[b] * pix(rr, cc);
                        end
                    end
                    v = rnd_shift(acc, 32);
                end else begin
                    // nearest, and the unused mode, ignore align
                    v = pix(clip_idx((longint'(r) * ih) / oh, ih),
                            clip_idx((longint'(c) * iw) / ow, iw));
                end
                if (v > 32767) begin v = 32767; e.sat = 1'b1; end
                if (v < -32768) begin v = -32768; e.sat = 1'b1; end
                e.pixel = v[15:0];
            end
            owed.push_back(e);
        endfunction

        function void check_result(logic signed [15:0] p, logic s, logic b);
            pix_result_t e;
            if (owed.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result pixel=%0d sat=%0b bad=%0b", p, s, b);
                return;
            end
            e = owed.pop_front();
            if (p !== e.pixel || s !== e.sat || b !== e.bad) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected pixel=%0d sat=%0b bad=%0b, got %0d %0b %0b",
                             e.pixel, e.sat, e.bad, p, s, b);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    iri_req_if req_ch ();
    iri_res_if res_ch ();

    image_resize_interpolator_top u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch.sink),
        .res     (res_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    resize_scoreboard sb = new();
    bit  filled [STORE_W*STORE_W];
    bit  quiet;
    bit  hold_req;
    int  idle_cycles;

    always #5 clk = ~clk;

    initial
    begin
        req_ch.valid    = 1'b0;
        req_ch.req_type = REQ_LOAD;
        req_ch.row      = '0;
        req_ch.col      = '0;
        req_ch.pixel_in = '0;
        res_ch.ready    = 1'b0;
    end

    // Check every result transfer at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
            sb.check_result(res_ch.pixel_out, res_ch.saturated, res_ch.bad_coordinate);
    end

    // Watchdog: count cycles in which neither channel makes a transfer.
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT) begin
            $display("tb_image_resize_interpolator_top: FAIL");
            $finish;
        end
    end

    initial idle_cycles = 0;

    // Result sink: random stall bursts, one long hold-off on request,
    // and always ready once the run turns quiet.
    initial
    begin
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_req) begin
                res_ch.ready <= 1'b0;
                repeat (400) @(negedge clk);
                hold_req = 1'b0;
                res_ch.ready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 18) - 1) @(negedge clk);
            end else
                res_ch.ready <= 1'b1;
        end
    end

    // Write one register: setup cycle, access cycle, then release.
    task automatic apb_write(reg_idx_t idx, logic [31:0] v);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= APB_ADDR_W'(idx * 4);
        pwdata  <= v;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        sb.set_reg(idx, v);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Drive one request and hold it until the transfer; assumes the
    // caller stands at a falling edge. Leave valid high for the next item. Random gaps drop it unless quiet.
    task automatic send_req(logic kind, int r, int c, logic [15:0] p);
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.row      <= r[11:0];
        req_ch.col      <= c[11:0];
        req_ch.pixel_in <= p;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        sb.note_request(kind, r, c, p);
        if (kind == REQ_LOAD && r < sb.eff(0) && c < sb.eff(1))
            filled[r * STORE_W + c] = 1'b1;
        @(negedge clk);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
    endtask

    // Drain all owed results, then give the engine a few spare cycles.
    task automatic wait_idle();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (sb.owed.size() > 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic configure(int ih, int iw, int oh, int ow, mode_t m, logic ac);
        wait_idle();
        apb_write(REG_IN_HEIGHT, 32'(ih));
        apb_write(REG_IN_WIDTH, 32'(iw));
        apb_write(REG_OUT_HEIGHT, 32'(oh));
        apb_write(REG_OUT_WIDTH, 32'(ow));
        apb_write(REG_MODE, 32'(m));
        apb_write(REG_ALIGN, 32'(ac));
        @(negedge clk);
    endtask

    // Load every entry of the active plane that has not been written yet,
    // so no query ever reads an unwritten entry.
    task automatic fill_plane();
        for (int r = 0; r < sb.eff(0); r++)
            for (int c = 0; c < sb.eff(1); c++)
                if (!filled[r * STORE_W + c])
                    send_req(REQ_LOAD, r, c, 16'($urandom_range(0, 16'hFFFF)));
    endtask

    task automatic random_item();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 60)
            send_req(REQ_QUERY, $urandom_range(0, sb.eff(2) - 1),
                     $urandom_range(0, sb.eff(3) - 1), 16'($urandom_range(0, 16'hFFFF)));
        else if (sel < 85)
            send_req(REQ_LOAD, $urandom_range(0, sb.eff(0) - 1),
                     $urandom_range(0, sb.eff(1) - 1), 16'($urandom_range(0, 16'hFFFF)));
        else
            // full-range positions: mostly out of the plane
            send_req(sel[0] ? REQ_QUERY : REQ_LOAD, $urandom_range(0, 4095),
                     $urandom_range(0, 4095), 16'($urandom_range(0, 16'hFFFF)));
    endtask

    initial
    begin
        int    ih, iw, oh, ow;
        mode_t m;
        quiet    = 1'b0;
        hold_req = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: a 2x2 checkerboard of the pixel extremes, upscaled.
        configure(2, 2, 3, 3, MODE_NEAREST, 1'b0);
        send_req(REQ_LOAD, 0, 0, 16'h7FFF);
        send_req(REQ_LOAD, 0, 1, 16'h8000);
        send_req(REQ_LOAD, 1, 0, 16'h8000);
        send_req(REQ_LOAD, 1, 1, 16'h7FFF);
        send_req(REQ_LOAD, 4095, 0, 16'h1234);   // bad load position
        send_req(REQ_LOAD, 0, 4095, 16'h4321);
        send_req(REQ_QUERY, 4095, 4095, 16'hFFFF); // bad query position
        for (int k = 0; k < 6; k++) begin
            m = (k == 0) ? MODE_NEAREST : (k < 3) ? MODE_BILINEAR :
                (k < 5) ? MODE_BICUBIC : MODE_UNUSED;
            configure(2, 2, 3, 3, m, k[0]);
            send_req(REQ_QUERY, 0, 0, 16'h0000);
            send_req(REQ_QUERY, 1, 1, 16'h0000);
            send_req(REQ_QUERY, 2, 2, 16'h0000);
        end

        // Random phases; a few pin the register extremes.
        for (int ph = 0; ph < 14; ph++) begin
            ih = $urandom_range(1, 8);
            iw = $urandom_range(1, 8);
            oh = $urandom_range(1, 24);
            ow = $urandom_range(1, 24);
            m  = mode_t'($urandom_range(0, 3));
            case (ph)
                1: begin ih = 511; iw = 1; end
                3: begin ih = 1; iw = 256; oh = 4096; ow = 1; end
                5: begin ih = 0; iw = 0; oh = 0; ow = 0; end
                7: begin oh = 8191; ow = 4096; m = MODE_BICUBIC; end
                9: begin ih = 256; iw = 1; m = MODE_BILINEAR; end
                default: ;
            endcase
            if (ph >= 12) quiet = 1'b1;
            configure(ih, iw, oh, ow, m, 1'($urandom_range(0, 1)));
            fill_plane();
            if (ph == 4) hold_req = 1'b1;
            repeat (45) random_item();
        end

        wait_idle();
        repeat (100) @(posedge clk);
        if (sb.mismatches == 0 && sb.owed.size() == 0)
            $display("tb_image_resize_interpolator_top: PASS");
        else
            $display("tb_image_resize_interpolator_top: FAIL");
        $finish;
    end
endmodule

FILE: image_resize_interpolator_top.f
rtl/iri_pkg.sv
rtl/iri_if.sv
rtl/iri_ram.sv
rtl/iri_div.sv
rtl/image_resize_interpolator_top.sv
test/tb_image_resize_interpolator_top.sv
